// ----- rtl/core/pss_pkg.sv -----
// pss_pkg: shared types, codes and helper functions for the pam site scanner
// depends on nothing; used by every module under rtl/core
`default_nettype none

package pss_pkg;

    // default sizes handed down from the top level
    localparam int MAX_WINDOW_DEF    = 32;
    localparam int MAX_PAM_DEF       = 8;
    localparam int POSITION_BITS_DEF = 32;

    // fixed by the field widths of the ports
    localparam int OUT_SLOTS   = 32;
    localparam int HALF_SLOTS  = 16;
    localparam int PAM_SLOTS   = 8;
    localparam int GUIDE_W     = 5;
    localparam int PAM_LEN_W   = 4;
    localparam int PAM_BASES_W = 24;
    localparam int TOTAL_W     = 6;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 24;
    localparam int HALF_W      = 48;

    typedef logic [2:0] base_t;

    localparam base_t CODE_A     = 3'd0;
    localparam base_t CODE_C     = 3'd1;
    localparam base_t CODE_G     = 3'd2;
    localparam base_t CODE_T     = 3'd3;
    localparam base_t CODE_N     = 3'd4;
    localparam base_t CODE_OTHER = 3'd5;
    localparam base_t CODE_NONE  = 3'd7;

    // configuration register indexes
    localparam logic [CFG_INDEX_W-1:0] REG_GUIDE_LENGTH = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_PAM_LENGTH   = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PAM_BASES    = 2'd2;

    localparam logic [GUIDE_W-1:0]     GUIDE_LENGTH_RST = 5'd19;
    localparam logic [PAM_LEN_W-1:0]   PAM_LENGTH_RST   = 4'd3;
    localparam logic [PAM_BASES_W-1:0] PAM_BASES_RST    = 24'd148;

    typedef struct packed {
        base_t base_code;
        logic  new_sequence;
    } in_t;

    typedef struct packed {
        logic [31:0]       guide_number;
        logic [31:0]       start_position;
        logic [31:0]       end_position;
        logic              forward_match;
        logic              reverse_match;
        logic [HALF_W-1:0] window_low;
        logic [HALF_W-1:0] window_high;
    } out_t;

    // one base entering the window
    typedef struct packed {
        logic  step;
        base_t base_code;
        logic  new_sequence;
    } step_t;

    // outcome of checking one window
    typedef struct packed {
        logic              emit;
        logic              fwd;
        logic              rev;
        logic [HALF_W-1:0] window_low;
        logic [HALF_W-1:0] window_high;
    } match_t;

    function automatic base_t complement_code(base_t c);
        base_t r;
        if (c <= CODE_T)
            r = CODE_T - c;
        else if (c == CODE_N)
            r = CODE_N;
        else
            r = CODE_NONE;
        return r;
    endfunction

    // codes six and seven fold into other
    function automatic base_t clip_code(base_t c);
        return (c > CODE_OTHER) ? CODE_OTHER : c;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/pss_window.sv -----
// pss_window: shift window of recent bases and the in-sequence position counter
// depends on pss_pkg
`default_nettype none

module pss_window #(
    parameter int MAX_WINDOW    = pss_pkg::MAX_WINDOW_DEF,
    parameter int POSITION_BITS = pss_pkg::POSITION_BITS_DEF
) (
    input  wire logic                     clk,
    input  wire logic                     rst_n,
    input  wire pss_pkg::step_t           step,
    output pss_pkg::base_t                bases [MAX_WINDOW],
    output logic [POSITION_BITS-1:0]      position
);

    pss_pkg::base_t             bases_reg [MAX_WINDOW];
    logic [POSITION_BITS-1:0]   pos_reg;
    logic [POSITION_BITS-1:0]   pos_next;

    // a new sequence restarts the count before its first base is checked
    assign position = step.new_sequence ? '0 : pos_reg;
    assign bases    = bases_reg;

    always_comb
    begin
        pos_next = pos_reg;
        if (step.step)
        begin
            // saturate at the top of the range
            if (position == '1)
                pos_next = position;
            else
                pos_next = position + POSITION_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            for (int k = 0; k < MAX_WINDOW; k++)
                bases_reg[k] <= pss_pkg::CODE_A;
        end
        else
        begin
            pos_reg <= pos_next;
            if (step.step)
            begin
                bases_reg[0] <= step.base_code;
                for (int k = 1; k < MAX_WINDOW; k++)
                    bases_reg[k] <= bases_reg[k-1];
            end
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/pss_match.sv -----
// pss_match: pam compare on both strands, n check and wildcard masking of one window
// depends on pss_pkg
`default_nettype none

module pss_match #(
    parameter int MAX_WINDOW    = pss_pkg::MAX_WINDOW_DEF,
    parameter int MAX_PAM       = pss_pkg::MAX_PAM_DEF,
    parameter int POSITION_BITS = pss_pkg::POSITION_BITS_DEF
) (
    input  wire pss_pkg::base_t                      bases [MAX_WINDOW],
    input  wire logic [POSITION_BITS-1:0]            position,
    input  wire pss_pkg::base_t                      base_code,
    input  wire logic [pss_pkg::GUIDE_W-1:0]         guide_length,
    input  wire logic [pss_pkg::PAM_LEN_W-1:0]       pam_length,
    input  wire logic [pss_pkg::PAM_BASES_W-1:0]     pam_bases,
    output pss_pkg::match_t                          result
);

    localparam int WIDX = (MAX_WINDOW > 1) ? $clog2(MAX_WINDOW) : 1;

    logic [pss_pkg::TOTAL_W-1:0] total;
    logic [pss_pkg::TOTAL_W-1:0] sel;
    logic [pss_pkg::TOTAL_W-1:0] fsel;
    logic [pss_pkg::TOTAL_W-1:0] off;
    logic [2:0]                  pidx;
    pss_pkg::base_t              raw [pss_pkg::OUT_SLOTS];
    pss_pkg::base_t              pc;
    pss_pkg::base_t              ic;
    pss_pkg::base_t              tgt;
    pss_pkg::base_t              outb;
    logic                        ok;
    logic                        fwd;
    logic                        rev;
    logic                        has_n;
    logic                        mask_f;
    logic                        mask_r;
    logic [pss_pkg::OUT_SLOTS-1:0] fwd_wild;
    logic [pss_pkg::OUT_SLOTS-1:0] rev_wild;

    assign total = pss_pkg::TOTAL_W'(guide_length) + pss_pkg::TOTAL_W'(pam_length);

    assign ok = (base_code != pss_pkg::CODE_N) && (32'(pam_length) <= MAX_PAM)
             && (32'(total) <= MAX_WINDOW) && (position >= POSITION_BITS'(total));

    // window in oldest-first order, zero past its end
    always_comb
    begin
        sel = '0;
        for (int w = 0; w < pss_pkg::OUT_SLOTS; w++)
        begin
            sel    = total - pss_pkg::TOTAL_W'(w) - pss_pkg::TOTAL_W'(1);
            raw[w] = pss_pkg::CODE_A;
            if ((pss_pkg::TOTAL_W'(w) < total) && (32'(sel) < MAX_WINDOW))
                raw[w] = bases[sel[WIDX-1:0]];
        end
    end

    // forward pam sits just before the newest base, reverse at the oldest end
    always_comb
    begin
        fwd      = 1'b1;
        rev      = 1'b1;
        fwd_wild = '0;
        rev_wild = '0;
        pc       = pss_pkg::CODE_A;
        ic       = pss_pkg::CODE_A;
        tgt      = pss_pkg::CODE_A;
        fsel     = '0;
        pidx     = '0;
        for (int q = 0; q < pss_pkg::PAM_SLOTS; q++)
        begin
            if (pss_pkg::PAM_LEN_W'(q) < pam_length)
            begin
                pc   = pam_bases[3*q +: 3];
                fsel = pss_pkg::TOTAL_W'(pam_length) - pss_pkg::TOTAL_W'(q)
                     - pss_pkg::TOTAL_W'(1);
                tgt  = (32'(fsel) < MAX_WINDOW) ? bases[fsel[WIDX-1:0]] : pss_pkg::CODE_NONE;
                if (pc != pss_pkg::CODE_N && (pc > pss_pkg::CODE_T || pc != tgt))
                    fwd = 1'b0;
                fwd_wild[q] = (pc == pss_pkg::CODE_N);

                pidx = 3'(pam_length - pss_pkg::PAM_LEN_W'(q) - pss_pkg::PAM_LEN_W'(1));
                ic   = pss_pkg::complement_code(pam_bases[5'(pidx) * 5'd3 +: 3]);
                if (ic != pss_pkg::CODE_N && (ic > pss_pkg::CODE_T || ic != raw[q]))
                    rev = 1'b0;
                rev_wild[q] = (ic == pss_pkg::CODE_N);
            end
        end
    end

    always_comb
    begin
        has_n = 1'b0;
        for (int w = 0; w < pss_pkg::OUT_SLOTS; w++)
            if (raw[w] == pss_pkg::CODE_N)
                has_n = 1'b1;
    end

    always_comb
    begin
        result        = '0;
        off           = '0;
        mask_f        = 1'b0;
        mask_r        = 1'b0;
        outb          = pss_pkg::CODE_A;
        result.emit   = ok && (fwd || rev) && !has_n;
        result.fwd    = fwd;
        result.rev    = rev;
        for (int w = 0; w < pss_pkg::OUT_SLOTS; w++)
        begin
            off    = pss_pkg::TOTAL_W'(w) - pss_pkg::TOTAL_W'(guide_length);
            mask_f = fwd && (pss_pkg::TOTAL_W'(w) >= pss_pkg::TOTAL_W'(guide_length))
                  && (pss_pkg::TOTAL_W'(w) < total) && fwd_wild[off[4:0]];
            mask_r = rev && (pss_pkg::TOTAL_W'(w) < pss_pkg::TOTAL_W'(pam_length))
                  && rev_wild[w];
            outb   = (mask_f || mask_r) ? pss_pkg::CODE_N : raw[w];
            if (w < pss_pkg::HALF_SLOTS)
                result.window_low[3*w +: 3] = outb;
            else
                result.window_high[3*(w-pss_pkg::HALF_SLOTS) +: 3] = outb;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/core/pam_site_scanner_unit.sv -----
// pam_site_scanner_unit: top level of the pam site scanner; uses pss_pkg, pss_window, pss_match
// path: accepted beat -> input register -> compare pass -> result register
// throughput: one base per cycle; the input register feeds a single compare pass
// into the result register, and the input stalls only while a held result beat is stalled
// reset: asynchronous active low; clears window, position, site count and valids,
// and returns config to its defaults
`default_nettype none

module pam_site_scanner_unit #(
    parameter int MAX_WINDOW    = pss_pkg::MAX_WINDOW_DEF,
    parameter int MAX_PAM       = pss_pkg::MAX_PAM_DEF,
    parameter int POSITION_BITS = pss_pkg::POSITION_BITS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  wire pss_pkg::in_t                    in_data,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output pss_pkg::out_t                        out_data,
    input  wire logic                            cfg_write,
    input  wire logic [pss_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [pss_pkg::CFG_DATA_W-1:0]  cfg_data
);

    localparam int EXT_BITS = (POSITION_BITS > 32) ? POSITION_BITS : 32;

    logic [pss_pkg::GUIDE_W-1:0]     guide_length_reg;
    logic [pss_pkg::PAM_LEN_W-1:0]   pam_length_reg;
    logic [pss_pkg::PAM_BASES_W-1:0] pam_bases_reg;

    logic                 in_valid_reg;
    pss_pkg::in_t         in_data_reg;
    logic                 out_valid_reg;
    logic                 out_valid_next;
    pss_pkg::out_t        out_data_reg;
    logic [31:0]          site_cnt_reg;
    logic [31:0]          site_cnt_next;

    logic                         advance;
    logic                         fire;
    pss_pkg::base_t               base_clip;
    pss_pkg::step_t               step;
    pss_pkg::base_t               bases [MAX_WINDOW];
    logic [POSITION_BITS-1:0]     position;
    pss_pkg::match_t              match;
    logic [pss_pkg::TOTAL_W-1:0]  total;
    logic [POSITION_BITS-1:0]     start_full;
    logic [EXT_BITS-1:0]          start_ext;
    logic [EXT_BITS-1:0]          end_ext;

    // result register free or being drained this cycle
    assign advance   = !out_valid_reg || !out_stall;
    assign fire      = in_valid_reg && advance;
    assign in_stall  = in_valid_reg && !advance;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

    assign base_clip         = pss_pkg::clip_code(in_data_reg.base_code);
    assign step.step         = fire;
    assign step.base_code    = base_clip;
    assign step.new_sequence = in_data_reg.new_sequence;

    pss_window #(
        .MAX_WINDOW    (MAX_WINDOW),
        .POSITION_BITS (POSITION_BITS)
    ) u_window (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (step),
        .bases    (bases),
        .position (position)
    );

    pss_match #(
        .MAX_WINDOW    (MAX_WINDOW),
        .MAX_PAM       (MAX_PAM),
        .POSITION_BITS (POSITION_BITS)
    ) u_match (
        .bases        (bases),
        .position     (position),
        .base_code    (base_clip),
        .guide_length (guide_length_reg),
        .pam_length   (pam_length_reg),
        .pam_bases    (pam_bases_reg),
        .result       (match)
    );

    assign total = pss_pkg::TOTAL_W'(guide_length_reg) + pss_pkg::TOTAL_W'(pam_length_reg);
    assign start_full = position - POSITION_BITS'(total);
    assign start_ext  = EXT_BITS'(start_full);
    assign end_ext    = EXT_BITS'(position);

    always_comb
    begin
        out_valid_next = out_valid_reg;
        site_cnt_next  = site_cnt_reg;
        if (advance)
            out_valid_next = fire && match.emit;
        if (fire && match.emit)
            site_cnt_next = site_cnt_reg + 32'd1;
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            guide_length_reg <= pss_pkg::GUIDE_LENGTH_RST;
            pam_length_reg   <= pss_pkg::PAM_LENGTH_RST;
            pam_bases_reg    <= pss_pkg::PAM_BASES_RST;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                pss_pkg::REG_GUIDE_LENGTH: guide_length_reg <= cfg_data[pss_pkg::GUIDE_W-1:0];
                pss_pkg::REG_PAM_LENGTH:   pam_length_reg   <= cfg_data[pss_pkg::PAM_LEN_W-1:0];
                pss_pkg::REG_PAM_BASES:    pam_bases_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            site_cnt_reg  <= '0;
        end
        else
        begin
            if (!in_stall)
                in_valid_reg <= in_valid;
            out_valid_reg <= out_valid_next;
            site_cnt_reg  <= site_cnt_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (!in_stall && in_valid)
            in_data_reg <= in_data;
        if (fire && match.emit)
        begin
            out_data_reg.guide_number   <= site_cnt_reg;
            out_data_reg.start_position <= start_ext[31:0];
            out_data_reg.end_position   <= end_ext[31:0];
            out_data_reg.forward_match  <= match.fwd;
            out_data_reg.reverse_match  <= match.rev;
            out_data_reg.window_low     <= match.window_low;
            out_data_reg.window_high    <= match.window_high;
        end
    end

`ifndef NO_ASSERTIONS
    // the site count has already moved past a held result beat
    a_site_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> site_cnt_reg == out_data_reg.guide_number + 32'd1)
        else $error("site count out of step with held result");

    a_some_strand: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (out_data_reg.forward_match || out_data_reg.reverse_match))
        else $error("result beat with no strand match");

    a_span: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |->
            out_data_reg.end_position - out_data_reg.start_position == 32'(total))
        else $error("window span differs from guide plus pam");

    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid_reg && out_stall && in_valid_reg))
        else $error("input stalled with free result register");
`endif

endmodule

`default_nettype wire

// ----- dv/tb.sv -----
// tb: self-checking bench for pam_site_scanner_unit, predicting each site beat from the base stream
// depends on pss_pkg and rtl/core/pam_site_scanner_unit.sv
`default_nettype none

module tb;
    import pss_pkg::*;

    localparam int    WIN_SLOTS     = MAX_WINDOW_DEF;
    localparam int    PAM_MAX       = MAX_PAM_DEF;
    localparam int    SETTLE_CYCLES = 6;
    localparam int    IDLE_LIMIT    = 2000;
    localparam int    LONG_HOLD     = 120;
    localparam base_t CODE_X6       = 3'd6;
    localparam base_t CODE_X7       = 3'd7;
    localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 2'd3;

    logic                   clk       = 1'b0;
    logic                   rst_n     = 1'b0;
    logic                   in_valid  = 1'b0;
    logic                   in_stall;
    in_t                    in_data   = '0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    out_t                   out_data;
    logic                   cfg_write = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data  = '0;

    pam_site_scanner_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever #10 clk = ~clk;
    end

    // scanner state as the predictor sees it
    base_t                  window_q [WIN_SLOTS];   // index 0 = newest base
    logic [31:0]            position_q;
    logic [31:0]            site_q;
    logic [GUIDE_W-1:0]     guide_len_q;
    logic [PAM_LEN_W-1:0]   pam_len_q;
    logic [PAM_BASES_W-1:0] pam_q;

    in_t  base_stream [$];
    out_t site_queue [$];
    int   beats_pushed   = 0;
    int   beats_taken    = 0;
    int   mismatches     = 0;
    int   stall_requests = 0;
    int   stall_served   = 0;
    int   gap_left       = 0;
    int   burst_left     = 0;
    int   hold_left      = 0;
    int   mode_left      = 0;
    int   stall_pct      = 0;
    int   idle_cycles    = 0;

    function automatic base_t pair_base(input base_t c);
        base_t r;
        case (c)
            CODE_A:  r = CODE_T;
            CODE_C:  r = CODE_G;
            CODE_G:  r = CODE_C;
            CODE_T:  r = CODE_A;
            CODE_N:  r = CODE_N;
            default: r = CODE_NONE;
        endcase
        return r;
    endfunction

    // checks the window ending before this base, then shifts the base in
    function automatic bit scan_base(input in_t beat, output out_t site);
        base_t             b;
        base_t             fc;
        base_t             rc;
        base_t             win [WIN_SLOTS];
        int unsigned       total;
        int unsigned       plen;
        int unsigned       w;
        int unsigned       q;
        bit                fwd;
        bit                rev;
        bit                has_n;
        bit                hit;
        logic [HALF_W-1:0] lo;
        logic [HALF_W-1:0] hi;
        b = (beat.base_code > CODE_OTHER) ? CODE_OTHER : beat.base_code;
        plen = 32'(pam_len_q);
        total = 32'(guide_len_q) + plen;
        site = '0;
        hit = 1'b0;
        if (beat.new_sequence)
            position_q = '0;
        if (b != CODE_N && plen <= PAM_MAX && total <= WIN_SLOTS && position_q >= total)
        begin
            fwd = 1'b1;
            rev = 1'b1;
            has_n = 1'b0;
            for (w = 0; w < total; w++)
            begin
                win[w] = window_q[total - 1 - w];
                if (win[w] == CODE_N)
                    has_n = 1'b1;
            end
            for (q = 0; q < plen; q++)
            begin
                fc = pam_q[3*q +: 3];
                rc = pair_base(pam_q[3*(plen - 1 - q) +: 3]);
                if (fc != CODE_N && (fc > CODE_T || fc != win[total - plen + q]))
                    fwd = 1'b0;
                if (rc != CODE_N && (rc > CODE_T || rc != win[q]))
                    rev = 1'b0;
            end
            if ((fwd || rev) && !has_n)
            begin
                // wildcard positions of each matching strand read back as N
                for (q = 0; q < plen; q++)
                begin
                    fc = pam_q[3*q +: 3];
                    rc = pair_base(pam_q[3*(plen - 1 - q) +: 3]);
                    if (fwd && fc == CODE_N)
                        win[total - plen + q] = CODE_N;
                    if (rev && rc == CODE_N)
                        win[q] = CODE_N;
                end
                lo = '0;
                hi = '0;
                for (w = 0; w < total; w++)
                begin
                    if (w < HALF_SLOTS)
                        lo[3*w +: 3] = win[w];
                    else
                        hi[3*(w - HALF_SLOTS) +: 3] = win[w];
                end
                site.guide_number   = site_q;
                site.start_position = position_q - total;
                site.end_position   = position_q;
                site.forward_match  = fwd;
                site.reverse_match  = rev;
                site.window_low     = lo;
                site.window_high    = hi;
                site_q++;
                hit = 1'b1;
            end
        end
        for (w = WIN_SLOTS - 1; w > 0; w--)
            window_q[w] = window_q[w - 1];
        window_q[0] = b;
        if (position_q != '1)
            position_q++;
        return hit;
    endfunction

    task automatic flag_mismatch(input string what);
        mismatches++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    task automatic check_field(input string name, input logic [HALF_W-1:0] got,
                               input logic [HALF_W-1:0] want, input logic [31:0] num);
        if (got !== want)
            flag_mismatch($sformatf("site %0d %s got %0h want %0h", num, name, got, want));
    endtask

    task automatic queue_site(input out_t s);
        site_queue.insert(site_queue.size(), s);
    endtask

    // sender: bursts of random length separated by random gaps
    always @(posedge clk)
    begin : beat_driver
        out_t site;
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                if (scan_base(in_data, site))
                    queue_site(site);
                beats_taken++;
            end
            if (!in_valid || !in_stall)
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    in_valid <= 1'b0;
                end
                else if (base_stream.size() > 0)
                begin
                    in_data <= base_stream.pop_front();
                    in_valid <= 1'b1;
                    burst_left--;
                    if (burst_left <= 0)
                    begin
                        burst_left = $urandom_range(1, 48);
                        gap_left = ($urandom_range(2) == 0) ? 0 : $urandom_range(1, 10);
                    end
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // receiver: stall density changes from stretch to stretch, plus requested long hold-offs
    always @(posedge clk)
    begin : site_receiver
        if (rst_n)
        begin
            if (hold_left > 0)
            begin
                hold_left--;
                out_stall <= 1'b1;
            end
            else if (stall_served != stall_requests && out_valid)
            begin
                hold_left = LONG_HOLD;
                stall_served++;
                out_stall <= 1'b1;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    mode_left = $urandom_range(8, 64);
                    case ($urandom_range(2))
                        0:       stall_pct = 0;
                        1:       stall_pct = 30;
                        default: stall_pct = 70;
                    endcase
                end
                mode_left--;
                out_stall <= ($urandom_range(99) < stall_pct);
            end
        end
    end

    always @(posedge clk)
    begin : site_check
        out_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (site_queue.size() == 0)
                flag_mismatch("site beat with nothing expected");
            else
            begin
                want = site_queue.pop_front();
                check_field("guide_number", HALF_W'(out_data.guide_number),
                            HALF_W'(want.guide_number), want.guide_number);
                check_field("start_position", HALF_W'(out_data.start_position),
                            HALF_W'(want.start_position), want.guide_number);
                check_field("end_position", HALF_W'(out_data.end_position),
                            HALF_W'(want.end_position), want.guide_number);
                check_field("forward_match", HALF_W'(out_data.forward_match),
                            HALF_W'(want.forward_match), want.guide_number);
                check_field("reverse_match", HALF_W'(out_data.reverse_match),
                            HALF_W'(want.reverse_match), want.guide_number);
                check_field("window_low", out_data.window_low, want.window_low,
                            want.guide_number);
                check_field("window_high", out_data.window_high, want.window_high,
                            want.guide_number);
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        if (!rst_n || cfg_write || (in_valid && !in_stall) || (out_valid && !out_stall))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    task automatic push_base(input base_t code, input bit fresh);
        in_t beat;
        beat.base_code = code;
        beat.new_sequence = fresh;
        base_stream.insert(base_stream.size(), beat);
        beats_pushed++;
    endtask

    function automatic base_t fill_wild(input base_t c);
        base_t r;
        r = (c > CODE_T) ? base_t'($urandom_range(CODE_A, CODE_T)) : c;
        return r;
    endfunction

    // a run of mostly clean bases with pam sites planted on either strand and random sequence restarts
    task automatic push_strand(input int len, input int noise_pct, input int plant_pct,
                               input int restart_pct);
        base_t planted [$];
        base_t code;
        int    i;
        int    q;
        int    p;
        int    roll;
        bit    fresh;
        p = (pam_len_q > PAM_MAX) ? PAM_MAX : int'(pam_len_q);
        for (i = 0; i < len; i++)
        begin
            fresh = (i == 0) || ($urandom_range(99) < restart_pct);
            if (planted.size() > 0)
                code = planted.pop_front();
            else
            begin
                roll = $urandom_range(99);
                code = base_t'($urandom_range(CODE_A, CODE_T));
                if (roll < noise_pct)
                    code = base_t'($urandom_range(CODE_N, CODE_NONE));
                else if (roll < noise_pct + plant_pct)
                begin
                    for (q = 0; q < p; q++)
                    begin
                        if (roll[0])
                            planted.insert(planted.size(), fill_wild(pam_q[3*q +: 3]));
                        else
                            planted.insert(planted.size(),
                                           fill_wild(pair_base(pam_q[3*(p - 1 - q) +: 3])));
                    end
                end
            end
            push_base(code, fresh);
        end
    endtask

    // waits until every beat is taken and every site has come back
    task automatic drain();
        @(posedge clk);
        while (beats_taken != beats_pushed || site_queue.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // leaves cfg_write high; the caller lowers it after the last write
    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [CFG_DATA_W-1:0] value);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        @(posedge clk);
        case (idx)
            REG_GUIDE_LENGTH: guide_len_q = value[GUIDE_W-1:0];
            REG_PAM_LENGTH:   pam_len_q = value[PAM_LEN_W-1:0];
            REG_PAM_BASES:    pam_q = value;
            default:          ;
        endcase
    endtask

    // unused upper bits of the length writes carry junk
    task automatic program_scan(input int guide, input int plen,
                                input logic [PAM_BASES_W-1:0] pam_bits);
        logic [CFG_DATA_W-1:0] junk;
        junk = CFG_DATA_W'($urandom);
        junk[GUIDE_W-1:0] = GUIDE_W'(guide);
        write_reg(REG_GUIDE_LENGTH, junk);
        junk = CFG_DATA_W'($urandom);
        junk[PAM_LEN_W-1:0] = PAM_LEN_W'(plen);
        write_reg(REG_PAM_LENGTH, junk);
        write_reg(REG_PAM_BASES, pam_bits);
        cfg_write <= 1'b0;
    endtask

    function automatic logic [PAM_BASES_W-1:0] random_pam(input int n_pct);
        logic [PAM_BASES_W-1:0] bits;
        int                     s;
        int                     roll;
        for (s = 0; s < PAM_MAX; s++)
        begin
            roll = $urandom_range(99);
            if (roll < n_pct)
                bits[3*s +: 3] = CODE_N;
            else if (roll < n_pct + 8)
                bits[3*s +: 3] = 3'($urandom_range(CODE_OTHER, CODE_NONE));
            else
                bits[3*s +: 3] = 3'($urandom_range(CODE_A, CODE_T));
        end
        return bits;
    endfunction

    initial
    begin : stimulus
        base_t                  lead [25];
        logic [PAM_BASES_W-1:0] pam_bits;
        int                     i;
        int                     guide;
        int                     plen;
        window_q = '{default: CODE_A};
        position_q = '0;
        site_q = '0;
        guide_len_q = GUIDE_LENGTH_RST;
        pam_len_q = PAM_LENGTH_RST;
        pam_q = PAM_BASES_RST;
        // guide with odd codes, NGG at the tail and CCN at the head, then a check,
        // an N that skips its check, and a base whose window holds that N
        lead = '{CODE_C, CODE_C, CODE_T, CODE_OTHER, CODE_X6, CODE_X7, CODE_A, CODE_C,
                 CODE_G, CODE_T, CODE_A, CODE_C, CODE_G, CODE_T, CODE_A, CODE_C, CODE_G,
                 CODE_T, CODE_A, CODE_A, CODE_G, CODE_G, CODE_C, CODE_N, CODE_G};
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        for (i = 0; i < 25; i++)
            push_base(lead[i], i == 0);
        drain();

        // reset settings, with one long receiver hold-off while beats keep coming
        stall_requests++;
        push_strand(120, 3, 8, 0);
        push_strand(120, 3, 8, 0);
        drain();
        push_strand(100, 3, 8, 0);
        push_strand(60, 25, 0, 6);
        drain();

        // widest window: 31 guide bases and a single pam base
        pam_bits = PAM_BASES_W'($urandom);
        program_scan(31, 1, pam_bits);
        push_strand(80, 2, 10, 0);
        push_strand(80, 2, 10, 0);
        drain();

        // one-base guide, longest pam with many wildcards
        program_scan(1, 8, random_pam(50));
        push_strand(80, 2, 20, 0);
        push_strand(80, 2, 20, 0);
        drain();

        // empty window: every non-N base is a site
        pam_bits = PAM_BASES_W'($urandom);
        write_reg(REG_SPARE, pam_bits);
        program_scan(0, 0, '0);
        stall_requests++;
        push_strand(80, 10, 0, 5);
        drain();

        // window longer than the scanner holds, all pam codes above N
        program_scan(31, 8, '1);
        push_strand(40, 2, 10, 0);
        drain();

        // pam longer than allowed
        pam_bits = PAM_BASES_W'($urandom);
        program_scan(2, $urandom_range(9, 15), pam_bits);
        push_strand(40, 2, 10, 0);
        drain();

        // all-wildcard pam: both strands match every clean window
        pam_bits = '0;
        pam_bits[2:0] = CODE_N;
        pam_bits[5:3] = CODE_N;
        program_scan(0, 2, pam_bits);
        push_strand(60, 5, 0, 3);
        drain();

        repeat (6)
        begin
            guide = $urandom_range(1) ? $urandom_range(0, 8) : $urandom_range(0, 31);
            plen = ($urandom_range(9) == 0) ? $urandom_range(9, 15) : $urandom_range(0, 8);
            program_scan(guide, plen, random_pam(20));
            push_strand(70, 3, 15, 1);
            drain();
        end

        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule

`default_nettype wire

// ----- sim.f -----
rtl/core/pss_pkg.sv
rtl/core/pss_window.sv
rtl/core/pss_match.sv
rtl/core/pam_site_scanner_unit.sv
dv/tb.sv
